// ----- design/sle_pkg.sv -----
// shared types and constants of the sorted list engine
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W  = 4;
	localparam int NUM_W  = 5;
	localparam int CAP_W  = 5;
	localparam int APB_W  = 32;
	localparam int ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_ORDER    = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT     = 3'd0,
		MODE_REMOVE     = 3'd1,
		MODE_REMOVE_ALL = 3'd2,
		MODE_GET        = 3'd3,
		MODE_FIND       = 3'd4,
		MODE_COUNT      = 3'd5
	} sle_mode_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_CMP  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_DEL  = 2'd3
	} sle_cell_op_t;

	// broadcast to every cell
	typedef struct packed {
		sle_cell_op_t              op;
		logic signed [DATA_W-1:0]  key;
		logic                      descending;
	} sle_cmd_t;

	// per-cell control from the top level
	typedef struct packed {
		logic occ;
		logic sel;
		logic at_p;
		logic ge_p;
	} sle_lane_t;

	// what a cell shows its neighbours
	typedef struct packed {
		logic signed [DATA_W-1:0] entry;
		logic                     ahead;
		logic                     equal;
	} sle_link_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] data;
		logic [NUM_W-1:0]         number;
		logic                     now_empty;
		logic                     now_full;
	} sle_res_t;

endpackage

`default_nettype wire

// ----- design/sle_req_if.sv -----
// request channel: mode, value and position with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface sle_req_if import sle_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);

endinterface

`default_nettype wire

// ----- design/sle_rsp_if.sv -----
// result channel: ok, data, number and list flags with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface sle_rsp_if import sle_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] data;
	logic [NUM_W-1:0]         number;
	logic                     now_empty;
	logic                     now_full;

	modport source (output valid, output ok, output data, output number,
		output now_empty, output now_full, input ready);
	modport sink (input valid, input ok, input data, input number,
		input now_empty, input now_full, output ready);

endinterface

`default_nettype wire

// ----- design/sle_cell.sv -----
// one list cell: holds an entry, compares it with the key and shifts with its neighbours
`timescale 1ns / 1ps
`default_nettype none

module sle_cell import sle_pkg::*; (
	input  logic                     clk,
	input  sle_cmd_t                 cmd,
	input  sle_lane_t                lane,
	input  sle_link_t                prev,
	input  sle_link_t                next,
	output sle_link_t                link,
	output logic signed [DATA_W-1:0] pick
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     ahead_q;
	logic                     equal_q;
	logic signed [DATA_W-1:0] pick_q;
	logic                     precedes;

	assign precedes = cmd.descending ? (entry_q > cmd.key) : (entry_q < cmd.key);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_CMP: begin
				ahead_q <= lane.occ & precedes;
				equal_q <= lane.occ & (entry_q == cmd.key);
				pick_q  <= lane.sel ? entry_q : '0;
			end
			CELL_INS: begin
				if (lane.at_p) begin
					entry_q <= cmd.key;
				end else if (lane.ge_p) begin
					entry_q <= prev.entry;
				end
			end
			// flags travel with the entry so a repeated removal can re-scan
			CELL_DEL: begin
				if (lane.ge_p) begin
					entry_q <= next.entry;
					ahead_q <= next.ahead;
					equal_q <= next.equal;
				end
			end
			default: begin
			end
		endcase
	end

	assign link.entry = entry_q;
	assign link.ahead = ahead_q;
	assign link.equal = equal_q;
	assign pick       = pick_q;

endmodule

`default_nettype wire

// ----- design/sorted_list_engine.sv -----
// top level of the sorted list engine: control sequencer, config registers and cell row
//
// Keeps up to DEPTH signed 32-bit values in sorted order, ascending or descending.
// Requests arrive on req (mode, value, position) and each gives exactly one result
// on rsp (ok, data, number, now_empty, now_full); transfers need valid and ready high.
// The APB port sets capacity_in_use (0x0) and order_descending (0x4); write these
// only while no request is in flight.
// Timing: every cell compares its entry with the key in the transfer cycle, the next
// cycle picks the first entry that does not precede the key (a carry across the
// flag vector) and shifts the row. Remove-all shifts the row once per removed entry,
// and count clears one match per cycle.
// A finished result sits in the output register; req accepts the next request
// while it waits, and a second result holds in the sequencer until rsp frees.
// Reset empties the list, restores capacity 16 and ascending order; entries keep
// whatever they hold and are never read until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine import sle_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	sle_req_if.sink           req,
	sle_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > NUM_W) ? CW : NUM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PURGE,
		S_TALLY,
		S_FIN
	} state_t;

	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [CW-1:0]            n_q, n_d;
	logic [DEPTH-1:0]         tally_q, tally_d;
	logic [CAP_W-1:0]         cap_q;
	logic                     desc_q;
	logic [MODE_W-1:0]        mode_q;
	logic signed [DATA_W-1:0] key_q;
	logic [POS_W-1:0]         pos_q;
	sle_res_t                 res_q, res_d, out_q;
	logic                     out_valid_q;
	logic                     out_free;
	logic                     done;
	logic                     accept;

	sle_cmd_t                 cmd;
	sle_cell_op_t             cell_op;
	sle_lane_t                lane [DEPTH];
	sle_link_t                link [DEPTH];
	logic signed [DATA_W-1:0] pick [DEPTH];
	logic signed [DATA_W-1:0] pick_or;

	logic [DEPTH:0]           b_vec, e_vec, b_inc, first_t, below;
	logic [CW-1:0]            p;
	logic                     hit;
	logic [MW-1:0]            eff;

	function automatic logic [NUM_W-1:0] to_num(input logic [MW-1:0] x);
		return x[NUM_W-1:0];
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_CAPACITY: cap_q  <= pwdata[CAP_W-1:0];
				REG_ORDER:    desc_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPACITY: prdata = APB_W'(cap_q);
			REG_ORDER:    prdata = APB_W'(desc_q);
			default:      prdata = '0;
		endcase
	end

	// capacity zero acts as one, above the row as the row
	always_comb begin
		if (cap_q == '0) begin
			eff = MW'(1);
		end else if (MW'(cap_q) > MW'(DEPTH)) begin
			eff = MW'(DEPTH);
		end else begin
			eff = MW'(cap_q);
		end
	end

	// flag vectors with an empty slot on top as the end marker
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			b_vec[i] = link[i].ahead;
			e_vec[i] = link[i].equal;
		end
		b_vec[DEPTH] = 1'b0;
		e_vec[DEPTH] = 1'b0;
	end

	// first entry that does not precede the key, found by the carry of b + 1
	assign b_inc   = b_vec + 1'b1;
	assign first_t = ~b_vec & b_inc;
	assign below   = (b_inc ^ b_vec) >> 1;
	assign hit     = |(first_t & e_vec);

	always_comb begin
		p = '0;
		for (int i = 0; i <= DEPTH; i++) begin
			p = p | (first_t[i] ? CW'(i) : '0);
		end
	end

	always_comb begin
		pick_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick_or = pick_or | pick[i];
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lane[i].occ  = (CW'(i) < cnt_q);
			lane[i].sel  = (32'(i) == 32'(req.position));
			lane[i].at_p = first_t[i];
			lane[i].ge_p = ~below[i];
		end
	end

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		tally_d = tally_q;
		cell_op = CELL_HOLD;
		done    = 1'b0;
		res_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cell_op = CELL_CMP;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (mode_q)
					MODE_INSERT: begin
						if (MW'(cnt_q) < eff) begin
							cell_op      = CELL_INS;
							cnt_d        = cnt_q + 1'b1;
							res_d.ok     = 1'b1;
							res_d.data   = key_q;
							res_d.number = to_num(MW'(p));
						end
						done = 1'b1;
					end
					MODE_REMOVE: begin
						if (hit) begin
							cell_op      = CELL_DEL;
							cnt_d        = cnt_q - 1'b1;
							res_d.ok     = 1'b1;
							res_d.data   = key_q;
							res_d.number = to_num(MW'(p));
						end
						done = 1'b1;
					end
					MODE_REMOVE_ALL: begin
						n_d     = '0;
						state_d = S_PURGE;
					end
					MODE_GET: begin
						if (MW'(pos_q) < MW'(cnt_q)) begin
							res_d.ok     = 1'b1;
							res_d.data   = pick_or;
							res_d.number = to_num(MW'(pos_q));
						end
						done = 1'b1;
					end
					MODE_FIND: begin
						if (hit) begin
							res_d.ok     = 1'b1;
							res_d.data   = key_q;
							res_d.number = to_num(MW'(p));
						end
						done = 1'b1;
					end
					MODE_COUNT: begin
						tally_d = e_vec[DEPTH-1:0];
						n_d     = '0;
						state_d = S_TALLY;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
			// one removal per cycle, the scan restarts on the shifted flags
			S_PURGE: begin
				if (hit) begin
					cell_op = CELL_DEL;
					cnt_d   = cnt_q - 1'b1;
					n_d     = n_q + 1'b1;
				end else begin
					res_d.ok     = (n_q != '0);
					res_d.data   = (n_q != '0) ? key_q : '0;
					res_d.number = to_num(MW'(n_q));
					done         = 1'b1;
				end
			end
			// clear the lowest match each cycle
			S_TALLY: begin
				if (tally_q != '0) begin
					tally_d = tally_q & (tally_q - 1'b1);
					n_d     = n_q + 1'b1;
				end else begin
					res_d.ok     = (n_q != '0);
					res_d.data   = key_q;
					res_d.number = to_num(MW'(n_q));
					done         = 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res_d.now_empty = (cnt_d == '0);
		res_d.now_full  = (MW'(cnt_d) >= eff);
		if (done) begin
			state_d = out_free ? S_IDLE : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			tally_q     <= '0;
			mode_q      <= '0;
			key_q       <= '0;
			pos_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			tally_q <= tally_d;
			if (accept) begin
				mode_q <= req.mode;
				key_q  <= req.value;
				pos_q  <= req.position;
			end
			if (done && out_free) begin
				out_q       <= res_d;
				out_valid_q <= 1'b1;
			end else if (done) begin
				res_q <= res_d;
			end else if (state_q == S_FIN && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.ok        = out_q.ok;
	assign rsp.data      = out_q.data;
	assign rsp.number    = out_q.number;
	assign rsp.now_empty = out_q.now_empty;
	assign rsp.now_full  = out_q.now_full;

	// cell row
	assign cmd.op         = cell_op;
	assign cmd.key        = (state_q == S_IDLE) ? req.value : key_q;
	assign cmd.descending = desc_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sle_link_t prev_l, next_l;
		if (g == 0) begin : g_first
			assign prev_l = '0;
		end else begin : g_mid_prev
			assign prev_l = link[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_l = '0;
		end else begin : g_mid_next
			assign next_l = link[g+1];
		end
		sle_cell u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.lane (lane[g]),
			.prev (prev_l),
			.next (next_l),
			.link (link[g]),
			.pick (pick[g])
		);
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		MW'(cnt_q) <= MW'(DEPTH))
		else $error("entry count beyond the row");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted request not executed next cycle");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> out_valid_q)
		else $error("result held back while output register free");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cell_op == CELL_INS) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow the list");

	a_purge_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PURGE && hit) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("removal did not shrink the list");

endmodule

`default_nettype wire

// ----- bench/sorted_list_engine_tb.sv -----
// self-checking bench for the sorted list engine: directed table, then random register phases
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned RESET_CYCLES = 7;
	localparam int unsigned N_PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 112;
	localparam int unsigned BIAS_RUN = 28;
	localparam int unsigned SETTLE = 24;  // count or remove-all over a full list of equal entries is the slowest request
	localparam int unsigned IDLE_PCT = 15;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SHOWN_MAX = 10;

	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam logic [ADDR_W-1:0] ADDR_CAPACITY = {1'b0, REG_CAPACITY, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_ORDER = {1'b0, REG_ORDER, 2'b00};
	localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh80000000;
	localparam sle_res_t NO_RES = '0;

	typedef struct {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] key;
		logic [POS_W-1:0]         pos;
		bit                       typed;
		sle_res_t                 want;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;

	sle_req_if req_ch ();
	sle_rsp_if rsp_ch ();

	sorted_list_engine #(.DEPTH(DEPTH)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the list and its registers
	logic signed [DATA_W-1:0] held [DEPTH];
	int unsigned held_len;
	logic [CAP_W-1:0] cap_setting;
	logic order_desc;

	sle_res_t pending [$];
	logic signed [DATA_W-1:0] key_pool [8];
	bit quiet;
	int unsigned errors;
	int unsigned sent;
	int unsigned received;
	int unsigned reg_writes;
	int unsigned cycles;

	int unsigned cap_plan [N_PHASES] = '{16, 3, 1, 0, 31, 16, 17, 8, 2, 16};
	bit desc_plan [N_PHASES] = '{0, 0, 1, 1, 0, 1, 1, 0, 0, 1};

	request_row_t directed [25] = '{
		'{MODE_GET,        32'sd0,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{MODE_REMOVE,     32'sd5,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{MODE_REMOVE_ALL, 32'sd5,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{MODE_FIND,       32'sd5,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{MODE_COUNT,      32'sd5,  4'd0,  1'b1, '{1'b0, 32'sd5, 5'd0, 1'b1, 1'b0}},
		'{MODE_SPARE_6,    -32'sd1, 4'd15, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{MODE_INSERT,     KEY_MAX, 4'd0,  1'b1, '{1'b1, KEY_MAX, 5'd0, 1'b0, 1'b0}},
		'{MODE_INSERT,     KEY_MIN, 4'd0,  1'b1, '{1'b1, KEY_MIN, 5'd0, 1'b0, 1'b0}},
		'{MODE_INSERT,     32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_INSERT,     32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_INSERT,     -32'sd1, 4'd0,  1'b0, NO_RES},
		'{MODE_SPARE_7,    KEY_MAX, 4'd0,  1'b0, NO_RES},
		'{MODE_GET,        32'sd0,  4'd15, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b0, 1'b0}},
		'{MODE_GET,        32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_GET,        32'sd0,  4'd4,  1'b0, NO_RES},
		'{MODE_FIND,       32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_COUNT,      32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_FIND,       32'sd7,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b0, 1'b0}},
		'{MODE_REMOVE,     32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_INSERT,     32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_REMOVE_ALL, 32'sd0,  4'd0,  1'b0, NO_RES},
		'{MODE_REMOVE,     -32'sd1, 4'd0,  1'b0, NO_RES},
		'{MODE_REMOVE_ALL, KEY_MIN, 4'd0,  1'b0, NO_RES},
		'{MODE_COUNT,      KEY_MAX, 4'd0,  1'b0, NO_RES},
		'{MODE_REMOVE_ALL, 32'sd7,  4'd0,  1'b1, '{1'b0, 32'sd0, 5'd0, 1'b0, 1'b0}}
	};

	always #10 clk = ~clk;

	function automatic int unsigned idle_pct();
		return quiet ? 0 : IDLE_PCT;
	endfunction

	function automatic int unsigned cap_limit();
		if (cap_setting == 0) return 1;
		if (cap_setting > DEPTH) return DEPTH;
		return cap_setting;
	endfunction

	function automatic bit precedes(input logic signed [DATA_W-1:0] e,
		input logic signed [DATA_W-1:0] k);
		return order_desc ? (e > k) : (e < k);
	endfunction

	// first place whose entry does not come before the key
	function automatic int unsigned slot_for(input logic signed [DATA_W-1:0] k);
		int unsigned i;
		i = 0;
		while (i < held_len && precedes(held[i], k)) i++;
		return i;
	endfunction

	function automatic int unsigned match_at(input logic signed [DATA_W-1:0] k);
		int unsigned i;
		i = slot_for(k);
		if (i < held_len && held[i] == k) return i;
		return held_len;
	endfunction

	function automatic void drop_entry(input int unsigned p);
		int unsigned i;
		for (i = p; i + 1 < held_len; i++) held[i] = held[i + 1];
		held_len--;
	endfunction

	function automatic sle_res_t list_op(input logic [MODE_W-1:0] mode,
		input logic signed [DATA_W-1:0] key, input logic [POS_W-1:0] pos);
		sle_res_t r;
		int unsigned i;
		int unsigned j;
		int unsigned hits;
		r = NO_RES;
		hits = 0;
		case (mode)
			MODE_INSERT: begin
				if (held_len < cap_limit()) begin
					i = slot_for(key);
					for (j = held_len; j > i; j--) held[j] = held[j - 1];
					held[i] = key;
					held_len++;
					r.ok = 1'b1;
					r.data = key;
					r.number = NUM_W'(i);
				end
			end
			MODE_REMOVE: begin
				i = match_at(key);
				if (i < held_len) begin
					r.ok = 1'b1;
					r.data = held[i];
					r.number = NUM_W'(i);
					drop_entry(i);
				end
			end
			MODE_REMOVE_ALL: begin
				i = match_at(key);
				while (i < held_len) begin
					drop_entry(i);
					hits++;
					i = match_at(key);
				end
				if (hits > 0) begin
					r.ok = 1'b1;
					r.data = key;
				end
				r.number = NUM_W'(hits);
			end
			MODE_GET: begin
				if (pos < held_len) begin
					r.ok = 1'b1;
					r.data = held[pos];
					r.number = NUM_W'(pos);
				end
			end
			MODE_FIND: begin
				i = match_at(key);
				if (i < held_len) begin
					r.ok = 1'b1;
					r.data = key;
					r.number = NUM_W'(i);
				end
			end
			MODE_COUNT: begin
				for (j = 0; j < held_len; j++) if (held[j] == key) hits++;
				r.ok = (hits > 0);
				r.data = key;
				r.number = NUM_W'(hits);
			end
			default: ;
		endcase
		r.now_empty = (held_len == 0);
		r.now_full = (held_len >= cap_limit());
		return r;
	endfunction

	// entered and left at a falling edge; valid stays high for the caller to reuse
	task automatic send_request(input logic [MODE_W-1:0] mode,
		input logic signed [DATA_W-1:0] key, input logic [POS_W-1:0] pos,
		input bit typed, input sle_res_t want);
		sle_res_t predicted;
		while ($urandom_range(99) < idle_pct()) begin
			req_ch.valid = 1'b0;
			req_ch.value = $urandom;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode = mode;
		req_ch.value = key;
		req_ch.position = pos;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = list_op(mode, key, pos);
		pending.push_back(typed ? want : predicted);
		sent++;
		@(negedge clk);
	endtask

	task automatic random_request(input bit filling);
		int unsigned roll;
		logic [MODE_W-1:0] mode;
		logic signed [DATA_W-1:0] key;
		logic [POS_W-1:0] pos;
		roll = $urandom_range(99);
		if (roll < (filling ? 50 : 18)) mode = MODE_INSERT;
		else if (roll < (filling ? 58 : 44)) mode = MODE_REMOVE;
		else if (roll < (filling ? 62 : 56)) mode = MODE_REMOVE_ALL;
		else if (roll < 70) mode = MODE_GET;
		else if (roll < 82) mode = MODE_FIND;
		else if (roll < 96) mode = MODE_COUNT;
		else if (roll < 98) mode = MODE_SPARE_6;
		else mode = MODE_SPARE_7;
		roll = $urandom_range(99);
		if (roll < 30 && held_len > 0) key = held[$urandom_range(held_len - 1)];
		else if (roll < 75) key = key_pool[$urandom_range(7)];
		else key = $urandom;
		if (held_len > 0 && $urandom_range(1)) pos = POS_W'($urandom_range(held_len - 1));
		else pos = POS_W'($urandom_range(15));
		send_request(mode, key, pos, 1'b0, NO_RES);
	endtask

	// also waits out any work on a result that is still leaving the block
	task automatic wait_drained();
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_CAPACITY) cap_setting = val[CAP_W-1:0];
		else order_desc = val[0];
		reg_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	always @(negedge clk) rsp_ch.ready = arst_n && ($urandom_range(99) >= idle_pct());

	always @(posedge clk) begin
		sle_res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			received++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MAX)
					$display("unexpected result transfer: ok=%0b data=%0d number=%0d",
						rsp_ch.ok, rsp_ch.data, rsp_ch.number);
			end else begin
				want = pending.pop_front();
				if (rsp_ch.ok !== want.ok || rsp_ch.data !== want.data ||
					rsp_ch.number !== want.number || rsp_ch.now_empty !== want.now_empty ||
					rsp_ch.now_full !== want.now_full) begin
					errors++;
					if (errors <= SHOWN_MAX) begin
						$display("result %0d: expected ok=%0b data=%0d number=%0d %s",
							received, want.ok, want.data, want.number,
							$sformatf("empty=%0b full=%0b", want.now_empty, want.now_full));
						$display("result %0d: got ok=%0b data=%0d number=%0d %s",
							received, rsp_ch.ok, rsp_ch.data, rsp_ch.number,
							$sformatf("empty=%0b full=%0b", rsp_ch.now_empty,
								rsp_ch.now_full));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				pending.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned ph;
		int unsigned n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_INSERT;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		quiet = 1'b0;
		errors = 0;
		sent = 0;
		received = 0;
		reg_writes = 0;
		cycles = 0;
		held_len = 0;
		cap_setting = CAP_RESET;
		order_desc = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[r])
			send_request(directed[r].mode, directed[r].key, directed[r].pos,
				directed[r].typed, directed[r].want);
		req_ch.valid = 1'b0;

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			// a list sorted one way is not sorted the other, so empty it first
			if (desc_plan[ph] != order_desc) begin
				while (held_len > 0) send_request(MODE_REMOVE_ALL, held[0], '0, 1'b0, NO_RES);
				req_ch.valid = 1'b0;
				wait_drained();
			end
			write_reg(ADDR_CAPACITY, APB_W'(cap_plan[ph]));
			write_reg(ADDR_ORDER, APB_W'(desc_plan[ph]));
			quiet = (ph == 5);
			key_pool[0] = KEY_MIN;
			key_pool[1] = KEY_MAX;
			key_pool[2] = 32'sd0;
			key_pool[3] = -32'sd1;
			key_pool[4] = 32'sd1;
			key_pool[5] = $urandom;
			key_pool[6] = $urandom;
			key_pool[7] = $urandom;
			// alternate runs that grow and shrink the list, ending on growth
			for (n = 0; n < ITEMS_PER_PHASE; n++) random_request(((n / BIAS_RUN) % 2) == 1);
			req_ch.valid = 1'b0;
		end

		wait_drained();
		$display("%0d requests and %0d results checked across %0d register writes",
			sent, received, reg_writes);
		$display("settings swept capacity 0 to 31 in both orders, %0d mismatches", errors);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
